// File: sv/rpt_pkg.sv
`default_nettype none

package rpt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 16;
    localparam int PRIO_W  = 16;

    localparam logic [PRIO_W-1:0] PRIO_ABSENT = '1;

    typedef enum logic [2:0] {
        ACT_SET    = 3'd0,
        ACT_APPEND = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_LOOKUP = 3'd4,
        ACT_LIST   = 3'd5
    } action_t;

endpackage

`default_nettype wire

// File: sv/request_priority_table_top.sv
`default_nettype none

// Associative table of rpt_pkg::ENTRIES slots mapping a 16-bit item number to a
// 16-bit priority. Each request (set, append, remove, clear, lookup, list entry)
// returns exactly one result transaction. A request that needs the table sweeps
// every slot through the key and priority memories, one slot per cycle, with one
// shared compare unit that looks for the key, the first free slot and the largest
// stored priority; clear and unused actions skip the sweep. The input is not
// ready while a request is in progress; a finished result sits in an output
// register, so the next request can be accepted and swept while it waits.
// Valid bits are flip-flops cleared at reset, so no clearing pass is needed.
module request_priority_table_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // item_key, new_priority
    input  wire logic [3:0]  s_axis_tuser,   // action, list_first
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // priority_out
    output logic [1:0]       m_axis_tuser    // found, status
);
    import rpt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE
    } state_t;

    state_t              state_reg;
    logic [ENTRIES-1:0]  valid_reg;
    logic [PRIO_W-1:0]   list_pos_reg;

    logic [2:0]          req_action_reg;
    logic [KEY_W-1:0]    req_key_reg;
    logic [PRIO_W-1:0]   req_prio_reg;

    logic [IDX_W-1:0]    scan_idx_reg;
    logic                cmp_en_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic [KEY_W-1:0]    key_rd_reg;
    logic [PRIO_W-1:0]   prio_rd_reg;

    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [PRIO_W-1:0]   hit_prio_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                any_reg;
    logic [PRIO_W-1:0]   max_reg;

    logic                out_valid_reg;
    logic                out_found_reg;
    logic                out_status_reg;
    logic [PRIO_W-1:0]   out_prio_reg;

    logic [KEY_W-1:0]    key_mem  [ENTRIES];
    logic [PRIO_W-1:0]   prio_mem [ENTRIES];

    logic                in_fire;
    logic                upd_go;
    logic                cmp_valid;

    // Decisions taken at the end of the sweep.
    logic                wr_en;
    logic [IDX_W-1:0]    wr_slot;
    logic [PRIO_W-1:0]   wr_prio;
    logic                rm_en;
    logic                clear_all;
    logic                pos_adv;
    logic                res_found;
    logic                res_status;
    logic [PRIO_W-1:0]   res_prio;
    logic [PRIO_W-1:0]   append_prio;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign upd_go        = (state_reg == ST_UPDATE) && (!out_valid_reg || m_axis_tready);
    assign cmp_valid     = valid_reg[cmp_idx_reg];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_prio_reg;
    assign m_axis_tuser  = {out_status_reg, out_found_reg};

    always_comb
    begin
        if (!any_reg)
            append_prio = '0;
        else if (max_reg == PRIO_ABSENT)
            append_prio = PRIO_ABSENT;
        else
            append_prio = max_reg + PRIO_W'(1);
    end

    always_comb
    begin
        wr_en      = 1'b0;
        wr_slot    = hit_reg ? hit_idx_reg : free_idx_reg;
        wr_prio    = req_prio_reg;
        rm_en      = 1'b0;
        clear_all  = 1'b0;
        pos_adv    = 1'b0;
        res_found  = 1'b0;
        res_status = 1'b0;
        res_prio   = PRIO_ABSENT;
        unique case (req_action_reg)
            ACT_SET, ACT_LIST:
            begin
                wr_prio   = (req_action_reg == ACT_LIST) ? list_pos_reg : req_prio_reg;
                pos_adv   = (req_action_reg == ACT_LIST);
                res_found = hit_reg;
                if (hit_reg || free_found_reg)
                begin
                    wr_en    = 1'b1;
                    res_prio = wr_prio;
                end
                else
                begin
                    res_status = 1'b1;
                end
            end
            ACT_APPEND:
            begin
                wr_prio = append_prio;
                if (hit_reg)
                begin
                    res_found = 1'b1;
                    res_prio  = hit_prio_reg;
                end
                else if (free_found_reg)
                begin
                    wr_en    = 1'b1;
                    res_prio = append_prio;
                end
                else
                begin
                    res_status = 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                if (hit_reg)
                begin
                    rm_en     = 1'b1;
                    res_found = 1'b1;
                    res_prio  = hit_prio_reg;
                end
            end
            ACT_CLEAR:
            begin
                clear_all = 1'b1;
            end
            ACT_LOOKUP:
            begin
                if (hit_reg)
                begin
                    res_found = 1'b1;
                    res_prio  = hit_prio_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Key and priority stores; the read port follows the sweep address.
    always_ff @(posedge clk)
    begin
        if (upd_go && wr_en)
        begin
            key_mem[wr_slot]  <= req_key_reg;
            prio_mem[wr_slot] <= wr_prio;
        end
        key_rd_reg  <= key_mem[scan_idx_reg];
        prio_rd_reg <= prio_mem[scan_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            list_pos_reg   <= '0;
            req_action_reg <= '0;
            req_key_reg    <= '0;
            req_prio_reg   <= '0;
            cmp_en_reg     <= 1'b0;
            cmp_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_status_reg <= 1'b0;
            out_prio_reg   <= '0;
            scan_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            hit_prio_reg   <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            any_reg        <= 1'b0;
            max_reg        <= '0;
        end
        else
        begin
            if (upd_go)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            // Shared compare unit: one slot per cycle, in the cycle after that slot's read.
            if (cmp_en_reg)
            begin
                if (cmp_valid)
                begin
                    if (!hit_reg && key_rd_reg == req_key_reg)
                    begin
                        hit_reg      <= 1'b1;
                        hit_idx_reg  <= cmp_idx_reg;
                        hit_prio_reg <= prio_rd_reg;
                    end
                    if (!any_reg || prio_rd_reg > max_reg)
                        max_reg <= prio_rd_reg;
                    any_reg <= 1'b1;
                end
                else if (!free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= cmp_idx_reg;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        req_action_reg <= s_axis_tuser[2:0];
                        req_key_reg    <= s_axis_tdata[15:0];
                        req_prio_reg   <= s_axis_tdata[31:16];
                        scan_idx_reg   <= '0;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        any_reg        <= 1'b0;
                        if (s_axis_tuser[2:0] == ACT_LIST && s_axis_tuser[3])
                        begin
                            valid_reg    <= '0;
                            list_pos_reg <= '0;
                        end
                        if (s_axis_tuser[2:0] == ACT_SET || s_axis_tuser[2:0] == ACT_APPEND ||
                            s_axis_tuser[2:0] == ACT_REMOVE ||
                            s_axis_tuser[2:0] == ACT_LOOKUP || s_axis_tuser[2:0] == ACT_LIST)
                            state_reg <= ST_SCAN;
                        else
                            state_reg <= ST_UPDATE;
                    end
                end
                ST_SCAN:
                begin
                    cmp_en_reg  <= 1'b1;
                    cmp_idx_reg <= scan_idx_reg;
                    if (scan_idx_reg == IDX_W'(ENTRIES - 1))
                        state_reg <= ST_LAST;
                    else
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
                ST_LAST:
                begin
                    cmp_en_reg <= 1'b0;
                    state_reg  <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (upd_go)
                    begin
                        if (clear_all)
                            valid_reg <= '0;
                        else if (wr_en)
                            valid_reg[wr_slot] <= 1'b1;
                        else if (rm_en)
                            valid_reg[hit_idx_reg] <= 1'b0;
                        if (pos_adv && list_pos_reg != PRIO_ABSENT)
                            list_pos_reg <= list_pos_reg + PRIO_W'(1);
                        out_found_reg  <= res_found;
                        out_status_reg <= res_status;
                        out_prio_reg   <= res_prio;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // Once a request is taken, the input stays closed until its result is issued.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("request accepted while another was in progress");

    // A new result only appears as the update step commits.
    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_UPDATE))
        else $error("result issued outside the update step");

    // A dropped insert never claims the item and always reports it as absent.
    a_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && m_axis_tdata == PRIO_ABSENT)
        else $error("inconsistent table-full result");

    // A pending result must not be overwritten by the next request.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("pending result lost");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_request_priority_table_top.sv
module tb_request_priority_table_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rpt_pkg::*;

    // Codes that the block answers without touching the table.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS  = 800;
    localparam int QUIET_TAIL    = 100;
    localparam int HOLD_CYCLES   = 600;
    localparam int HOLD_AFTER    = 150;
    localparam int DRAIN_CYCLES  = 2 * (ENTRIES + 3);
    localparam int WATCHDOG_MAX  = 4000;

    typedef struct packed {
        logic [2:0]  act;
        logic [15:0] key;
        logic [15:0] prio;
        logic        first;
    } request_t;

    typedef struct packed {
        logic        found;
        logic [15:0] prio;
        logic        status;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    request_t pending_q[$];
    answer_t  answers_q[$];
    logic [15:0] key_pool[$];

    // Shadow copy of the table.
    logic        ent_valid[ENTRIES];
    logic [15:0] ent_key[ENTRIES];
    logic [15:0] ent_prio[ENTRIES];
    logic [15:0] list_pos;

    request_t cur_req;
    logic     quiet = 1'b0;
    int       idle_left = 0;
    int       stall_left = 0;
    int       hold_left = 0;
    logic     hold_done = 1'b0;
    int       n_results = 0;
    int       errors = 0;
    int       dead_cycles = 0;
    logic     drv_valid;
    logic     mon_ready;

    request_priority_table_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic store_entry(int hit, int spare, logic [15:0] k, logic [15:0] p);
        int s;
        s = (hit >= 0) ? hit : spare;
        if (s < 0)
            return 1'b0;
        ent_valid[s] = 1'b1;
        ent_key[s]   = k;
        ent_prio[s]  = p;
        return 1'b1;
    endfunction

    function automatic answer_t predict_request(request_t r);
        answer_t     a;
        int          hit;
        int          spare;
        logic        any;
        logic [15:0] top;
        logic [15:0] pos;
        a.found  = 1'b0;
        a.prio   = PRIO_ABSENT;
        a.status = 1'b0;
        if (r.act == ACT_LIST && r.first)
        begin
            for (int i = 0; i < ENTRIES; i++)
                ent_valid[i] = 1'b0;
            list_pos = '0;
        end
        hit   = -1;
        spare = -1;
        any   = 1'b0;
        top   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (ent_valid[i])
            begin
                if (hit < 0 && ent_key[i] == r.key)
                    hit = i;
                if (!any || ent_prio[i] > top)
                    top = ent_prio[i];
                any = 1'b1;
            end
            else if (spare < 0)
            begin
                spare = i;
            end
        end
        case (r.act)
            ACT_SET:
            begin
                a.found = (hit >= 0);
                if (store_entry(hit, spare, r.key, r.prio))
                    a.prio = r.prio;
                else
                    a.status = 1'b1;
            end
            ACT_APPEND:
            begin
                if (hit >= 0)
                begin
                    a.found = 1'b1;
                    a.prio  = ent_prio[hit];
                end
                else
                begin
                    // The new priority saturates rather than wrapping to zero.
                    if (!any)
                        pos = '0;
                    else if (top == PRIO_ABSENT)
                        pos = PRIO_ABSENT;
                    else
                        pos = top + 16'd1;
                    if (store_entry(-1, spare, r.key, pos))
                        a.prio = pos;
                    else
                        a.status = 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                if (hit >= 0)
                begin
                    a.found = 1'b1;
                    a.prio  = ent_prio[hit];
                    ent_valid[hit] = 1'b0;
                end
            end
            ACT_CLEAR:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    ent_valid[i] = 1'b0;
            end
            ACT_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    a.found = 1'b1;
                    a.prio  = ent_prio[hit];
                end
            end
            ACT_LIST:
            begin
                pos = list_pos;
                a.found = (hit >= 0);
                if (store_entry(hit, spare, r.key, pos))
                    a.prio = pos;
                else
                    a.status = 1'b1;
                // The position moves on even when the insert was dropped.
                if (list_pos != PRIO_ABSENT)
                    list_pos = list_pos + 16'd1;
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    task automatic queue_request(logic [2:0] act, logic [15:0] key, logic [15:0] prio,
                                 logic first);
        request_t r;
        r.act   = act;
        r.key   = key;
        r.prio  = prio;
        r.first = first;
        pending_q.push_back(r);
        key_pool.push_back(key);
        if (key_pool.size() > 32)
            void'(key_pool.pop_front());
    endtask

    // Mostly reuse recent item numbers so that hits are common.
    function automatic logic [15:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_prio();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 16'h0000;
        if (sel == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Driver: offers queued requests and predicts each one as it is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet = (pending_q.size() < QUIET_TAIL);
            if (s_axis_tvalid && s_axis_tready)
                answers_q.push_back(predict_request(cur_req));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                drv_valid = 1'b0;
                if (idle_left > 0)
                begin
                    idle_left--;
                end
                else if (pending_q.size() > 0 && (quiet || $urandom_range(0, 7) != 0))
                begin
                    cur_req = pending_q.pop_front();
                    drv_valid = 1'b1;
                    s_axis_tdata <= {cur_req.prio, cur_req.key};
                    s_axis_tuser <= {cur_req.first, cur_req.act};
                end
                else if (pending_q.size() > 0)
                begin
                    idle_left = $urandom_range(0, 12);
                end
                s_axis_tvalid <= drv_valid;
            end
        end
    end

    // Monitor: checks each result transaction and throttles the output side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results++;
                if (answers_q.size() == 0)
                begin
                    $error("result transaction with no request outstanding");
                    errors++;
                end
                else
                begin
                    automatic answer_t exp = answers_q.pop_front();
                    if (m_axis_tuser[0] !== exp.found)
                    begin
                        $error("found: expected %0d, actual %0d", exp.found, m_axis_tuser[0]);
                        errors++;
                    end
                    if (m_axis_tdata !== exp.prio)
                    begin
                        $error("priority_out: expected %0d, actual %0d", exp.prio,
                               m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser[1] !== exp.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp.status,
                               m_axis_tuser[1]);
                        errors++;
                    end
                end
            end
            mon_ready = 1'b1;
            if (hold_left > 0)
            begin
                hold_left--;
                mon_ready = 1'b0;
            end
            else if (!hold_done && n_results >= HOLD_AFTER)
            begin
                // A long hold-off lets results back up until the input stalls.
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                mon_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                mon_ready = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                mon_ready = 1'b0;
            end
            m_axis_tready <= mon_ready;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                dead_cycles = 0;
            else
                dead_cycles++;
            if (dead_cycles >= WATCHDOG_MAX)
            begin
                $display("tb_request_priority_table_top failed");
                $finish;
            end
        end
    end

    initial
    begin
        int made;
        int kind;
        int n;
        int sel;
        logic [2:0] act;

        for (int i = 0; i < ENTRIES; i++)
        begin
            ent_valid[i] = 1'b0;
            ent_key[i]   = '0;
            ent_prio[i]  = '0;
        end
        list_pos = '0;

        // Directed part.
        queue_request(ACT_LOOKUP, 16'h0000, 16'h0000, 1'b0);
        queue_request(ACT_APPEND, 16'h0000, 16'h0000, 1'b0);
        queue_request(ACT_APPEND, 16'h0000, 16'hFFFF, 1'b0);
        queue_request(ACT_SET,    16'hFFFF, 16'hFFFF, 1'b0);
        queue_request(ACT_APPEND, 16'h1234, 16'h0000, 1'b0);
        queue_request(ACT_SET,    16'h0000, 16'h0000, 1'b1);
        queue_request(ACT_LOOKUP, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_request(ACT_REMOVE, 16'hFFFF, 16'h0000, 1'b0);
        queue_request(ACT_REMOVE, 16'hFFFF, 16'h0000, 1'b0);
        queue_request(ACT_SET,    16'h5A5A, 16'h8001, 1'b0);
        queue_request(ACT_CLEAR,  16'h0000, 16'h0000, 1'b0);
        queue_request(ACT_LOOKUP, 16'h0000, 16'h0000, 1'b0);
        queue_request(ACT_SPARE_6, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_request(ACT_SPARE_7, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_request(ACT_LIST,   16'h0005, 16'hFFFF, 1'b1);
        queue_request(ACT_LIST,   16'hA5A5, 16'h0000, 1'b0);
        queue_request(ACT_LIST,   16'h0005, 16'h0000, 1'b0);
        queue_request(ACT_LIST,   16'h0007, 16'h0000, 1'b1);
        queue_request(ACT_APPEND, 16'h0008, 16'h0000, 1'b0);
        queue_request(ACT_REMOVE, 16'h0007, 16'h0000, 1'b0);
        queue_request(ACT_SET,    16'hAAAA, 16'h5555, 1'b1);
        queue_request(ACT_LOOKUP, 16'hAAAA, 16'h0000, 1'b0);
        queue_request(ACT_CLEAR,  16'hFFFF, 16'hFFFF, 1'b1);

        // Random part, in episodes: table fills, mixed traffic and noise.
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 1)
            begin
                n = $urandom_range(60, 72);
                if ($urandom_range(0, 1) == 0)
                begin
                    for (int i = 0; i < n; i++)
                        queue_request(ACT_LIST,
                                      ($urandom_range(0, 9) == 0) ? pick_key() : 16'($urandom),
                                      16'($urandom), (i == 0));
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                        queue_request(($urandom_range(0, 1) == 0) ? ACT_APPEND : ACT_SET,
                                      16'($urandom), pick_prio(), 1'($urandom_range(0, 1)));
                end
                // Inserts of new items into a table that is probably full.
                for (int i = 0; i < 4; i++)
                    queue_request(($urandom_range(0, 1) == 0) ? ACT_APPEND : ACT_SET,
                                  16'($urandom), pick_prio(), 1'b0);
                queue_request(ACT_LOOKUP, pick_key(), 16'($urandom), 1'b0);
                made += n + 5;
            end
            else if (kind <= 7)
            begin
                n = $urandom_range(10, 40);
                for (int i = 0; i < n; i++)
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 20)
                        act = ACT_SET;
                    else if (sel < 40)
                        act = ACT_APPEND;
                    else if (sel < 55)
                        act = ACT_REMOVE;
                    else if (sel < 58)
                        act = ACT_CLEAR;
                    else if (sel < 80)
                        act = ACT_LOOKUP;
                    else if (sel < 95)
                        act = ACT_LIST;
                    else
                        act = ($urandom_range(0, 1) == 0) ? ACT_SPARE_6 : ACT_SPARE_7;
                    queue_request(act, pick_key(), pick_prio(), ($urandom_range(0, 9) == 0));
                    if (act != ACT_SPARE_6 && act != ACT_SPARE_7)
                        made++;
                end
            end
            else
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    queue_request(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                                  1'($urandom_range(0, 1)));
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (answers_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb_request_priority_table_top passed");
        else
            $display("tb_request_priority_table_top failed");
        $finish;
    end

endmodule

// File: files.f
sv/rpt_pkg.sv
sv/request_priority_table_top.sv
tb/sv/tb_request_priority_table_top.sv
